@@ sv/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg - shared types and constants of the line point generator
// Register indexes of the configuration port and the record types that
// travel between the scan sequencer and the error step unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;

    // field widths
    localparam int unsigned COORD_W = 6;
    localparam int unsigned TILE_W  = 16;
    localparam int unsigned MAP_W   = 7;

    // error step: remainder in [0, 2D), step of 2*delta with |delta| <= D
    typedef struct packed {
        logic [6:0]        rem;     // current remainder
        logic signed [7:0] delta2;  // signed step, twice the minor increment
        logic [6:0]        two_d;   // modulus 2*|d_major|
    } t_step_in;

    typedef struct packed {
        logic [6:0] rem;            // remainder after the step
        logic       q_inc;          // quotient goes up by one
        logic       q_dec;          // quotient goes down by one
    } t_step_out;

endpackage : lpg_pkg

`default_nettype wire

@@ sv/lpg_step_unit.sv @@
// ----------------------------------------------------------------------------
// lpg_step_unit - error step of the rounded minor coordinate
// An add, two compares and one correction: moves the remainder by the step and wraps it
// back into [0, 2D), reporting the carry into the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_step_unit (
    input  wire lpg_pkg::t_step_in  i_step,
    output lpg_pkg::t_step_out      o_step
);
    import lpg_pkg::*;

    logic signed [8:0] sum;
    logic signed [8:0] two_d_s;
    logic signed [8:0] wrapped;

    // raw sum and single correction
    always_comb begin
        sum     = $signed({2'b00, i_step.rem}) + 9'(i_step.delta2);
        two_d_s = $signed({2'b00, i_step.two_d});
        o_step.q_inc = 1'b0;
        o_step.q_dec = 1'b0;
        if (sum >= two_d_s) begin
            wrapped      = sum - two_d_s;
            o_step.q_inc = 1'b1;
        end else if (sum < 9'sd0) begin
            wrapped      = sum + two_d_s;
            o_step.q_dec = 1'b1;
        end else begin
            wrapped = sum;
        end
        o_step.rem = wrapped[6:0];
    end

endmodule : lpg_step_unit

`default_nettype wire

@@ sv/lpg_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lpg_cfg_regs - map size registers
// Holds map width and height; writes to unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lpg_pkg::MAP_W-1:0]     i_cfg_data,
    output logic                               o_cfg_ready,
    output logic [lpg_pkg::MAP_W-1:0]          o_map_width,
    output logic [lpg_pkg::MAP_W-1:0]          o_map_height
);
    import lpg_pkg::*;

    logic [MAP_W-1:0] r_map_width;
    logic [MAP_W-1:0] r_map_height;

    // always able to take a write
    assign o_cfg_ready  = 1'b1;
    assign o_map_width  = r_map_width;
    assign o_map_height = r_map_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width  <= 7'd64;
            r_map_height <= 7'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAP_WIDTH:  r_map_width  <= i_cfg_data;
                CFG_MAP_HEIGHT: r_map_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule : lpg_cfg_regs

`default_nettype wire

@@ sv/line_point_generator.sv @@
// ----------------------------------------------------------------------------
// line_point_generator - raster points of a straight line
// Scans the major axis from the larger to the smaller endpoint and steps the
// rounded minor coordinate with an add/compare error unit, one major-axis position a cycle.
//
//   channel   handshake                 payload
//   request   i_start, o_busy           i_first_x/y, i_second_x/y, i_tile_code
//   point     o_point_valid (strobe)    o_point_x/y, o_tile_out, o_final_point
//   config    i_cfg_valid, o_cfg_ready  i_cfg_index, i_cfg_data
//
// A request is latched, set up (deltas, direction), scanned over each major-axis
// position (1..64) and flushed. Each point is held back in a pending register
// so that the last one can carry final_point.
// Reset is synchronous, active low, and needs no clearing pass.
// Points are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
`default_nettype none

module line_point_generator #(
    parameter int unsigned MAP_SIDE = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [lpg_pkg::COORD_W-1:0]   i_first_x,
    input  wire logic [lpg_pkg::COORD_W-1:0]   i_first_y,
    input  wire logic [lpg_pkg::COORD_W-1:0]   i_second_x,
    input  wire logic [lpg_pkg::COORD_W-1:0]   i_second_y,
    input  wire logic [lpg_pkg::TILE_W-1:0]    i_tile_code,
    output logic                               o_point_valid,
    output logic [lpg_pkg::COORD_W-1:0]        o_point_x,
    output logic [lpg_pkg::COORD_W-1:0]        o_point_y,
    output logic [lpg_pkg::TILE_W-1:0]         o_tile_out,
    output logic                               o_final_point,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lpg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lpg_pkg::MAP_W-1:0]     i_cfg_data
);
    import lpg_pkg::*;

    localparam logic [COORD_W-1:0] SIDE_MAX = COORD_W'(MAP_SIDE - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state r_state;

    // latched request
    logic [COORD_W-1:0] r_x1, r_y1, r_x2, r_y2;
    logic [TILE_W-1:0]  r_tile;

    // scan state
    logic               r_x_major;
    logic               r_vert;
    logic               r_m_neg;
    logic [COORD_W-1:0] r_major;
    logic [COORD_W-1:0] r_lo;
    logic [COORD_W-1:0] r_minor0;
    logic signed [6:0]  r_q;
    logic [6:0]         r_rem;
    logic signed [7:0]  r_delta2;
    logic [6:0]         r_two_d;

    // held-back point
    logic               r_pend_v;
    logic [COORD_W-1:0] r_pend_x, r_pend_y;

    logic [MAP_W-1:0] map_width, map_height;

    t_step_in  step_in;
    t_step_out step_out;

    // configuration registers
    lpg_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_cfg_ready  (o_cfg_ready),
        .o_map_width  (map_width),
        .o_map_height (map_height)
    );

    // error step unit, reused on every scan cycle
    assign step_in.rem    = r_rem;
    assign step_in.delta2 = r_delta2;
    assign step_in.two_d  = r_two_d;

    lpg_step_unit u_step (
        .i_step (step_in),
        .o_step (step_out)
    );

    assign o_busy = (r_state != S_IDLE);

    // endpoint saturation to the map side
    function automatic logic [COORD_W-1:0] clamp_side(input logic [COORD_W-1:0] v,
                                                      input logic [COORD_W-1:0] vmax);
        clamp_side = (v > vmax) ? vmax : v;
    endfunction

    // setup: deltas, major axis and initial error terms
    logic signed [6:0] dx, dy, d_major, d_minor, n_adx, n_ady;
    logic              n_x_major;
    logic [6:0]        n_d;
    logic signed [7:0] two_minor, n_delta2;
    always_comb begin
        dx        = $signed({1'b0, r_x2}) - $signed({1'b0, r_x1});
        dy        = $signed({1'b0, r_y2}) - $signed({1'b0, r_y1});
        n_adx     = dx[6] ? -dx : dx;
        n_ady     = dy[6] ? -dy : dy;
        n_x_major = (dx != 7'sd0) && (n_adx >= n_ady);
        d_major   = n_x_major ? dx : dy;
        d_minor   = n_x_major ? dy : dx;
        n_d       = d_major[6] ? 7'(-d_major) : 7'(d_major);
        // step is twice the minor delta, sign set by the scan direction
        two_minor = $signed({d_minor, 1'b0});
        n_delta2  = d_major[6] ? two_minor : (8'sd0 - two_minor);
    end

    // candidate point of the current scan position
    logic signed [7:0]  minor_s;
    logic [COORD_W-1:0] n_minor, cand_x, cand_y;
    logic               cand_ok;
    always_comb begin
        minor_s = $signed({2'b00, r_minor0}) + 8'(r_q)
                  - ((r_m_neg && (r_rem == 7'd0)) ? 8'sd1 : 8'sd0);
        n_minor = minor_s[COORD_W-1:0];
        cand_x  = r_x_major ? r_major : n_minor;
        cand_y  = r_x_major ? n_minor : r_major;
        cand_ok = ({1'b0, cand_x} < map_width) && ({1'b0, cand_y} < map_height);
    end

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pend_v      <= 1'b0;
            o_point_valid <= 1'b0;
        end else begin
            o_point_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_x1    <= clamp_side(i_first_x, SIDE_MAX);
                        r_y1    <= clamp_side(i_first_y, SIDE_MAX);
                        r_x2    <= clamp_side(i_second_x, SIDE_MAX);
                        r_y2    <= clamp_side(i_second_y, SIDE_MAX);
                        r_tile  <= i_tile_code;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_x_major <= n_x_major;
                    r_vert    <= (dx == 7'sd0);
                    r_m_neg   <= d_minor[6];
                    r_minor0  <= n_x_major ? r_y1 : r_x1;
                    if (n_x_major) begin
                        r_major <= (r_x1 > r_x2) ? r_x1 : r_x2;
                        r_lo    <= (r_x1 > r_x2) ? r_x2 : r_x1;
                    end else begin
                        r_major <= (r_y1 > r_y2) ? r_y1 : r_y2;
                        r_lo    <= (r_y1 > r_y2) ? r_y2 : r_y1;
                    end
                    // scan from the second endpoint when it is the larger one
                    r_q      <= d_major[6] ? 7'sd0 : d_minor;
                    r_rem    <= n_d;
                    r_two_d  <= 7'(n_d << 1);
                    r_delta2 <= n_delta2;
                    r_pend_v <= 1'b0;
                    r_state  <= S_SCAN;
                end
                S_SCAN: begin
                    if (cand_ok) begin
                        if (r_pend_v) begin
                            o_point_valid <= 1'b1;
                            o_point_x     <= r_pend_x;
                            o_point_y     <= r_pend_y;
                            o_tile_out    <= r_tile;
                            o_final_point <= 1'b0;
                        end
                        r_pend_v <= 1'b1;
                        r_pend_x <= cand_x;
                        r_pend_y <= cand_y;
                    end
                    if (!r_vert) begin
                        r_rem <= step_out.rem;
                        if (step_out.q_inc) begin
                            r_q <= r_q + 7'sd1;
                        end else if (step_out.q_dec) begin
                            r_q <= r_q - 7'sd1;
                        end
                    end
                    r_major <= r_major - 6'd1;
                    if (r_major == r_lo) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (r_pend_v) begin
                        o_point_valid <= 1'b1;
                        o_point_x     <= r_pend_x;
                        o_point_y     <= r_pend_y;
                        o_tile_out    <= r_tile;
                        o_final_point <= 1'b1;
                    end
                    r_pend_v <= 1'b0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule : line_point_generator

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench - self-checking bench for the line point generator
// Sends line requests through the start/busy port and checks every strobed
// point against a scan-and-round predictor kept in the bench. Covers
// directed edge lines, several map window settings (zero, one, full,
// oversized), ignored register indexes, back-to-back and random traffic.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpg_pkg::*;

    // register indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int COORD_MAX    = 63;
    localparam int DRAIN_CYCLES = 72;    // latch, setup, a full 64-position scan and flush, with margin
    localparam int STALL_LIMIT  = 2000;  // cycles with nothing accepted
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] x2;
        logic [COORD_W-1:0] y2;
        logic [TILE_W-1:0]  tile;
    } t_line_req;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [TILE_W-1:0]  tile;
        logic               last;
    } t_line_point;

    // DUT signals
    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [COORD_W-1:0] i_first_x;
    logic [COORD_W-1:0] i_first_y;
    logic [COORD_W-1:0] i_second_x;
    logic [COORD_W-1:0] i_second_y;
    logic [TILE_W-1:0]  i_tile_code;
    logic               o_point_valid;
    logic [COORD_W-1:0] o_point_x;
    logic [COORD_W-1:0] o_point_y;
    logic [TILE_W-1:0]  o_tile_out;
    logic               o_final_point;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MAP_W-1:0]   i_cfg_data;

    // bench state
    t_line_point pending_points[$];
    int  map_cols = 64;
    int  map_rows = 64;
    bit  idle_on  = 1'b1;
    int  mismatch_count = 0;
    int  points_checked = 0;
    int  lines_sent     = 0;
    int  blank_lines    = 0;
    int  reg_writes     = 0;
    int  stall_cycles   = 0;

    line_point_generator #(.MAP_SIDE(64)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_tile_code  (i_tile_code),
        .o_point_valid(o_point_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_tile_out   (o_tile_out),
        .o_final_point(o_final_point),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10ns;
        i_clk = 1'b1;
        #10ns;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic int abs_int(int v);
        return (v < 0) ? -v : v;
    endfunction

    // num/den rounded, halves away from zero
    function automatic int round_div(int num, int den);
        int n;
        int d;
        n = num;
        d = den;
        if (d < 0) begin
            d = -d;
            n = -n;
        end
        if (n >= 0)
            return (2 * n + d) / (2 * d);
        return -((2 * (-n) + d) / (2 * d));
    endfunction

    function automatic int clip_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Scan the major axis from high to low, round the minor coordinate and
    // queue the visible points. The newest point is held back so the last
    // one can be tagged.
    function automatic void predict_line(t_line_req req);
        int x1;
        int y1;
        int x2;
        int y2;
        int dx;
        int dy;
        int hi;
        int lo;
        int px;
        int py;
        bit x_major;
        bit have_held;
        t_line_point held;
        x1 = req.x1;
        y1 = req.y1;
        x2 = req.x2;
        y2 = req.y2;
        dx = x2 - x1;
        dy = y2 - y1;
        x_major = (dx != 0) && (abs_int(dx) >= abs_int(dy));
        have_held = 1'b0;
        held = '0;
        if (x_major) begin
            hi = (x1 > x2) ? x1 : x2;
            lo = (x1 > x2) ? x2 : x1;
        end else begin
            hi = (y1 > y2) ? y1 : y2;
            lo = (y1 > y2) ? y2 : y1;
        end
        for (int pos = hi; pos >= lo; pos--) begin
            if (x_major) begin
                px = pos;
                py = y1 + round_div((pos - x1) * dy, dx);
            end else if (dx == 0) begin
                px = x1;
                py = pos;
            end else begin
                py = pos;
                px = x1 + round_div((pos - y1) * dx, dy);
            end
            if (px >= 0 && py >= 0 && px < map_cols && py < map_rows) begin
                if (have_held)
                    pending_points = {pending_points, held};
                held.x    = px[COORD_W-1:0];
                held.y    = py[COORD_W-1:0];
                held.tile = req.tile;
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            pending_points = {pending_points, held};
        end else begin
            blank_lines++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: %s", msg);
    endfunction

    // compare each strobed point with the oldest expected one
    always @(posedge i_clk) begin : point_check
        t_line_point got;
        t_line_point want;
        if (i_rst_n && o_point_valid) begin
            got = '{o_point_x, o_point_y, o_tile_out, o_final_point};
            if (pending_points.size() == 0) begin
                note_mismatch($sformatf("unexpected point x=%0d y=%0d tile=%h final=%0d",
                                        got.x, got.y, got.tile, got.last));
            end else begin
                want = pending_points.pop_front();
                points_checked++;
                if (got.x !== want.x || got.y !== want.y || got.tile !== want.tile ||
                    got.last !== want.last)
                    note_mismatch($sformatf(
                        "point exp x=%0d y=%0d tile=%h final=%0d, got x=%0d y=%0d tile=%h final=%0d",
                        want.x, want.y, want.tile, want.last,
                        got.x, got.y, got.tile, got.last));
            end
        end
    end

    // watchdog: ends the run when nothing is accepted for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_point_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TIMEOUT: %0d cycles with no handshake", stall_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // random gap before the next line request
    task automatic maybe_idle();
        int gap;
        if (idle_on && $urandom_range(99) < 33) begin
            gap = $urandom_range(1, ($urandom_range(3) == 0) ? 80 : 12);
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // send one line request and queue its expected points on acceptance
    task automatic send_line(t_line_req req);
        maybe_idle();
        i_start     <= 1'b1;
        i_first_x   <= req.x1;
        i_first_y   <= req.y1;
        i_second_x  <= req.x2;
        i_second_y  <= req.y2;
        i_tile_code <= req.tile;
        do @(posedge i_clk); while (o_busy);
        predict_line(req);
        lines_sent++;
    endtask

    task automatic send_xy(int x1, int y1, int x2, int y2, logic [TILE_W-1:0] tile);
        t_line_req req;
        req = '{x1[COORD_W-1:0], y1[COORD_W-1:0], x2[COORD_W-1:0], y2[COORD_W-1:0], tile};
        send_line(req);
    endtask

    // stop issuing, let every expected point arrive, then let the block flush
    task automatic wait_idle();
        i_start <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write; the bench copy follows on the handshake
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [MAP_W-1:0] value);
        if (idle_on && $urandom_range(99) < 33)
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        case (idx)
            CFG_MAP_WIDTH:  map_cols = value;
            CFG_MAP_HEIGHT: map_rows = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_map(int cols, int rows);
        wait_idle();
        write_register(CFG_MAP_WIDTH, cols[MAP_W-1:0]);
        write_register(CFG_MAP_HEIGHT, rows[MAP_W-1:0]);
    endtask

    function automatic int pick_map_size();
        if ($urandom_range(3) == 0)
            return $urandom_range(0, 127);
        return $urandom_range(1, 64);
    endfunction

    // random line of one of several shapes
    function automatic t_line_req random_line();
        int x1;
        int y1;
        int x2;
        int y2;
        int d;
        int t;
        x1 = $urandom_range(0, COORD_MAX);
        y1 = $urandom_range(0, COORD_MAX);
        x2 = $urandom_range(0, COORD_MAX);
        y2 = $urandom_range(0, COORD_MAX);
        case ($urandom_range(5))
            // short lines
            1: begin
                x2 = clip_coord(x1 + $urandom_range(0, 8) - 4);
                y2 = clip_coord(y1 + $urandom_range(0, 8) - 4);
            end
            // horizontal or vertical
            2: begin
                if ($urandom_range(1))
                    x2 = x1;
                else
                    y2 = y1;
            end
            // exact diagonal, either direction
            3: begin
                d  = $urandom_range(1, 20);
                x1 = $urandom_range(0, COORD_MAX - d);
                y1 = $urandom_range(0, COORD_MAX - d);
                x2 = x1 + d;
                y2 = y1 + d;
                if ($urandom_range(1)) begin
                    t = x1; x1 = x2; x2 = t;
                end
                if ($urandom_range(1)) begin
                    t = y1; y1 = y2; y2 = t;
                end
            end
            // endpoints on the map edges
            4: begin
                x1 = ($urandom_range(2) == 0) ? x1 : $urandom_range(1) * COORD_MAX;
                y1 = ($urandom_range(2) == 0) ? y1 : $urandom_range(1) * COORD_MAX;
                x2 = ($urandom_range(2) == 0) ? x2 : $urandom_range(1) * COORD_MAX;
                y2 = ($urandom_range(2) == 0) ? y2 : $urandom_range(1) * COORD_MAX;
            end
            // single point
            5: begin
                x2 = x1;
                y2 = y1;
            end
            default: ;
        endcase
        return '{x1[COORD_W-1:0], y1[COORD_W-1:0], x2[COORD_W-1:0], y2[COORD_W-1:0],
                 TILE_W'($urandom_range(0, 65535))};
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // edge lines, rounding ties and scan directions at the reset map size
    task automatic test_directed_lines();
        send_xy(0, 0, 0, 0, 16'h0000);      // single point at origin
        send_xy(63, 63, 63, 63, 16'hFFFF);  // single point at far corner
        send_xy(0, 0, 63, 0, 16'h5555);     // full horizontal
        send_xy(0, 63, 0, 0, 16'hAAAA);     // full vertical, first end high
        send_xy(0, 0, 63, 63, 16'h1234);    // |dx| == |dy| scans x
        send_xy(63, 0, 0, 63, 16'h8001);
        send_xy(0, 0, 63, 1, 16'h00FF);     // shallow
        send_xy(0, 0, 1, 63, 16'hFF00);     // steep
        send_xy(0, 0, 2, 1, 16'h0F0F);      // positive half rounds up
        send_xy(0, 1, 2, 0, 16'hF0F0);      // negative half rounds down
        send_xy(1, 0, 0, 2, 16'h3C3C);      // y-major negative half
        send_xy(0, 0, 6, 3, 16'hC3C3);
        send_xy(63, 10, 0, 20, 16'h7FFF);
        send_xy(10, 5, 12, 40, 16'h0001);
        send_xy(40, 63, 20, 0, 16'h8000);
        send_xy(31, 32, 32, 31, 16'hBEEF);
        send_xy(0, 63, 63, 0, 16'h0ACE);
        send_xy(62, 1, 61, 2, 16'hFACE);
    endtask

    // map window settings: one tile, zero, full, oversized and uneven sizes
    task automatic test_map_window();
        int cols_list[9] = '{1, 0, 64, 127, 65, 32, 1, 64, 64};
        int rows_list[9] = '{1, 64, 0, 127, 100, 17, 64, 1, 64};
        for (int s = 0; s < 9; s++) begin
            set_map(cols_list[s], rows_list[s]);
            // writes to unused indexes must leave the map alone
            if (s == 5) begin
                write_register(CFG_SPARE_2, MAP_W'($urandom_range(0, 127)));
                write_register(CFG_SPARE_3, 7'h7F);
                write_register(CFG_SPARE_2, 7'h00);
            end
            send_xy(0, 0, 63, 63, TILE_W'($urandom_range(0, 65535)));
            send_xy(63, 0, 0, 63, TILE_W'($urandom_range(0, 65535)));
            repeat (8) send_line(random_line());
        end
    endtask

    // requests with no gaps at all
    task automatic test_back_to_back();
        set_map(64, 64);
        idle_on = 1'b0;
        repeat (80) send_line(random_line());
        idle_on = 1'b1;
    endtask

    // random traffic with a new map size every few dozen lines
    task automatic test_random_lines();
        for (int phase = 0; phase < 5; phase++) begin
            if (phase == 0)
                set_map(64, 64);
            else
                set_map(pick_map_size(), pick_map_size());
            repeat (40) send_line(random_line());
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_first_x   <= '0;
        i_first_y   <= '0;
        i_second_x  <= '0;
        i_second_y  <= '0;
        i_tile_code <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_MAP_WIDTH;
        i_cfg_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_lines();
        test_map_window();
        test_back_to_back();
        test_random_lines();

        wait_idle();
        if (pending_points.size() != 0) begin
            note_mismatch($sformatf("%0d expected points never arrived",
                                    pending_points.size()));
        end

        $display("Summary: %0d line requests, %0d points checked, %0d lines fully off-map",
                 lines_sent, points_checked, blank_lines);
        $display("Summary: %0d register writes, %0d mismatches", reg_writes, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
